### rtl/tty_fifo_dma_device_top_assert.svh
// Assertion macros used by the checker file.
`ifndef TTY_FIFO_DMA_DEVICE_TOP_ASSERT_SVH
`define TTY_FIFO_DMA_DEVICE_TOP_ASSERT_SVH

// Same-cycle implication, off during reset.
`define TFD_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, off during reset.
`define TFD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, always checked.
`define TFD_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### rtl/tfd_pkg.sv
// ----------------------------------------------------------------------------
// tfd_pkg
// Types and codes of the virtual terminal device.
// ----------------------------------------------------------------------------
package tfd_pkg;

    localparam int FIFO_DEPTH_DEF = 128;

    localparam logic [1:0] MODE_WRITE = 2'd0;
    localparam logic [1:0] MODE_READ  = 2'd1;
    localparam logic [1:0] MODE_HOST  = 2'd2;
    localparam logic [1:0] MODE_RESP  = 2'd3;

    localparam logic [11:0] OFS_PUT_CHAR    = 12'h000;
    localparam logic [11:0] OFS_BYTES_READY = 12'h004;
    localparam logic [11:0] OFS_CMD         = 12'h008;
    localparam logic [11:0] OFS_PTR_LOW     = 12'h010;
    localparam logic [11:0] OFS_LEN         = 12'h014;
    localparam logic [11:0] OFS_PTR_HIGH    = 12'h018;

    localparam logic [31:0] CMD_IRQ_OFF = 32'd0;
    localparam logic [31:0] CMD_IRQ_ON  = 32'd1;
    localparam logic [31:0] CMD_SEND    = 32'd2;
    localparam logic [31:0] CMD_READ    = 32'd3;

    localparam logic [3:0] OP_PUTC     = 4'd0;
    localparam logic [3:0] OP_PTR_LOW  = 4'd1;
    localparam logic [3:0] OP_PTR_HIGH = 4'd2;
    localparam logic [3:0] OP_LEN      = 4'd3;
    localparam logic [3:0] OP_IRQ      = 4'd4;
    localparam logic [3:0] OP_SEND     = 4'd5;
    localparam logic [3:0] OP_READ     = 4'd6;
    localparam logic [3:0] OP_BAD_CMD  = 4'd7;
    localparam logic [3:0] OP_BAD_WR   = 4'd8;
    localparam logic [3:0] OP_RD_READY = 4'd9;
    localparam logic [3:0] OP_BAD_RD   = 4'd10;
    localparam logic [3:0] OP_HOST     = 4'd11;
    localparam logic [3:0] OP_RESP     = 4'd12;

    localparam logic [2:0] KIND_STATUS = 3'd0;
    localparam logic [2:0] KIND_BUS_RD = 3'd1;
    localparam logic [2:0] KIND_TO_HOST = 3'd2;
    localparam logic [2:0] KIND_MEM_RD = 3'd3;
    localparam logic [2:0] KIND_MEM_WR = 3'd4;

    localparam logic [2:0] ERR_OK      = 3'd0;
    localparam logic [2:0] ERR_OFFSET  = 3'd1;
    localparam logic [2:0] ERR_CMD     = 3'd2;
    localparam logic [2:0] ERR_EXCEED  = 3'd3;
    localparam logic [2:0] ERR_REFUSED = 3'd4;

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_SEND = 2'd1;
    localparam logic [1:0] PH_RECV = 2'd2;

    typedef struct packed {
        logic [3:0]  op;
        logic [31:0] wdata;
        logic [7:0]  data;
    } t_op;

endpackage

### rtl/tfd_if.sv
// ----------------------------------------------------------------------------
// tfd_in_if / tfd_out_if
// Request and result channels of the virtual terminal device.
// ----------------------------------------------------------------------------
interface tfd_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  mode;
    logic [11:0] offset;
    logic [31:0] wdata;
    logic [7:0]  byte_in;

    modport source (output valid, mode, offset, wdata, byte_in, input ready);
    modport sink   (input valid, mode, offset, wdata, byte_in, output ready);
endinterface

interface tfd_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  kind;
    logic [31:0] read_data;
    logic [63:0] mem_address;
    logic [7:0]  data_byte;
    logic        dma_done;
    logic        irq;
    logic [2:0]  error;
    logic        last;

    modport source (output valid, kind, read_data, mem_address, data_byte, dma_done, irq,
                    error, last, input ready);
    modport sink   (input valid, kind, read_data, mem_address, data_byte, dma_done, irq,
                    error, last, output ready);
endinterface

### rtl/tty_fifo_dma_device_top.sv
// ----------------------------------------------------------------------------
// tty_fifo_dma_device_top
// Virtual terminal device with receive FIFO and byte-paced DMA.
// ----------------------------------------------------------------------------
// Usage:
//   i_in carries one request per handshake: a bus write, a bus read, a byte
//   from the host or a memory response. o_out carries the results; each
//   request gives one result, a send-buffer memory response that is not the
//   final one gives two (byte to host, then the next memory read request),
//   and the last one of a request has last set.
//   A request passes through the decode queue and then the result register.
//   Throughput: one request per cycle while o_out does not stall; a two-result
//   request holds the result register for both of its results.
//   A two-entry decode queue separates i_in from the executing stage; the
//   single result register sets the pace when o_out stalls. i_in.ready
//   drops only when the queue is full.
//   Reset clears the FIFO pointers, interrupt enable, buffer registers and
//   any DMA in progress; FIFO contents are not cleared.
// ----------------------------------------------------------------------------
module tty_fifo_dma_device_top #(
    parameter int FIFO_DEPTH = tfd_pkg::FIFO_DEPTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    tfd_in_if.sink    i_in,
    tfd_out_if.source o_out
);
    import tfd_pkg::*;

    t_op  op;
    logic op_valid;
    logic op_ready;

    tfd_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (i_in),
        .o_op       (op),
        .o_op_valid (op_valid),
        .i_op_ready (op_ready)
    );

    tfd_back #(
        .FIFO_DEPTH (FIFO_DEPTH)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_op       (op),
        .i_op_valid (op_valid),
        .o_op_ready (op_ready),
        .o_out      (o_out)
    );

endmodule

### rtl/tfd_front.sv
// ----------------------------------------------------------------------------
// tfd_front
// Accepts requests, decodes them into operations, queues two of them.
// ----------------------------------------------------------------------------
module tfd_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    tfd_in_if.sink        i_in,
    output tfd_pkg::t_op  o_op,
    output logic          o_op_valid,
    input  logic          i_op_ready
);
    import tfd_pkg::*;

    t_op        dec;
    logic       push;
    logic       pop;
    t_op        r_q [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;

    always_comb begin
        dec.op    = OP_RESP;
        dec.wdata = i_in.wdata;
        dec.data  = (i_in.mode == MODE_WRITE) ? i_in.wdata[7:0] : i_in.byte_in;
        case (i_in.mode)
            MODE_WRITE: begin
                case (i_in.offset)
                    OFS_PUT_CHAR: dec.op = OP_PUTC;
                    OFS_PTR_LOW:  dec.op = OP_PTR_LOW;
                    OFS_PTR_HIGH: dec.op = OP_PTR_HIGH;
                    OFS_LEN:      dec.op = OP_LEN;
                    OFS_CMD: begin
                        if (i_in.wdata inside {CMD_IRQ_OFF, CMD_IRQ_ON}) begin
                            dec.op = OP_IRQ;
                        end else if (i_in.wdata == CMD_SEND) begin
                            dec.op = OP_SEND;
                        end else if (i_in.wdata == CMD_READ) begin
                            dec.op = OP_READ;
                        end else begin
                            dec.op = OP_BAD_CMD;
                        end
                    end
                    default:      dec.op = OP_BAD_WR;
                endcase
            end
            MODE_READ: begin
                dec.op = (i_in.offset == OFS_BYTES_READY) ? OP_RD_READY : OP_BAD_RD;
            end
            MODE_HOST: begin
                dec.op = OP_HOST;
            end
            default: begin
                dec.op = OP_RESP;
            end
        endcase
    end

    assign i_in.ready = (r_cnt != 2'd2);
    assign push       = i_in.valid && i_in.ready;
    assign o_op_valid = (r_cnt != 2'd0);
    assign pop        = o_op_valid && i_op_ready;
    assign o_op       = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= dec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (pop) begin
                r_rp <= ~r_rp;
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (pop && !push) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

endmodule

### rtl/tfd_back.sv
// ----------------------------------------------------------------------------
// tfd_back
// Executes operations: receive FIFO, DMA sequencing, result register.
// ----------------------------------------------------------------------------
module tfd_back #(
    parameter int FIFO_DEPTH = tfd_pkg::FIFO_DEPTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  tfd_pkg::t_op  i_op,
    input  logic          i_op_valid,
    output logic          o_op_ready,
    tfd_out_if.source     o_out
);
    import tfd_pkg::*;

    localparam int CW = $clog2(FIFO_DEPTH + 1);
    localparam int HW = $clog2(FIFO_DEPTH);

    logic [7:0]    r_store [FIFO_DEPTH];

    logic [HW-1:0] r_head,    n_head;
    logic [CW-1:0] r_count,   n_count;
    logic          r_irq_en,  n_irq_en;
    logic [63:0]   r_buf_addr, n_buf_addr;
    logic [31:0]   r_buf_len, n_buf_len;
    logic [1:0]    r_phase,   n_phase;
    logic [63:0]   r_ptr,     n_ptr;
    logic [31:0]   r_left,    n_left;
    logic          r_second,  n_second;

    logic          r_valid;
    logic [2:0]    r_kind,    n_kind;
    logic [31:0]   r_rd,      n_rd;
    logic [63:0]   r_addr,    n_addr;
    logic [7:0]    r_byte,    n_byte;
    logic          r_from_mem, n_from_mem;
    logic          r_done,    n_done;
    logic          r_irq,     n_irq;
    logic [2:0]    r_err,     n_err;
    logic          r_last,    n_last;
    logic [7:0]    r_rdata;

    logic          load;
    logic          we;
    logic [CW:0]   pos_sum;
    logic [HW-1:0] wpos;
    logic [HW-1:0] head_inc;
    logic          full;

    assign load     = i_op_valid && (!r_valid || o_out.ready);
    assign full     = (r_count == CW'(FIFO_DEPTH));
    assign head_inc = (r_head == HW'(FIFO_DEPTH - 1)) ? '0 : r_head + HW'(1);

    always_comb begin
        pos_sum = (CW+1)'(r_head) + (CW+1)'(r_count);
        if (pos_sum >= (CW+1)'(FIFO_DEPTH)) begin
            pos_sum = pos_sum - (CW+1)'(FIFO_DEPTH);
        end
        wpos = pos_sum[HW-1:0];
    end

    always_comb begin
        n_head     = r_head;
        n_count    = r_count;
        n_irq_en   = r_irq_en;
        n_buf_addr = r_buf_addr;
        n_buf_len  = r_buf_len;
        n_phase    = r_phase;
        n_ptr      = r_ptr;
        n_left     = r_left;
        n_second   = 1'b0;
        n_kind     = KIND_STATUS;
        n_rd       = '0;
        n_addr     = '0;
        n_byte     = '0;
        n_from_mem = 1'b0;
        n_done     = 1'b0;
        n_err      = ERR_OK;
        n_last     = 1'b1;
        we         = 1'b0;
        case (i_op.op)
            OP_PUTC: begin
                n_kind = KIND_TO_HOST;
                n_byte = i_op.data;
            end
            OP_PTR_LOW:  n_buf_addr[31:0]  = i_op.wdata;
            OP_PTR_HIGH: n_buf_addr[63:32] = i_op.wdata;
            OP_LEN:      n_buf_len = i_op.wdata;
            OP_IRQ:      n_irq_en = i_op.wdata[0];
            OP_SEND, OP_READ: begin
                if (r_phase != PH_IDLE) begin
                    n_err = ERR_REFUSED;
                end else if (i_op.op == OP_READ && r_buf_len > 32'(r_count)) begin
                    n_err = ERR_EXCEED;
                end else if (r_buf_len == '0) begin
                    n_err = ERR_OK;
                end else if (i_op.op == OP_SEND) begin
                    n_phase = PH_SEND;
                    n_ptr   = r_buf_addr;
                    n_left  = r_buf_len;
                    n_kind  = KIND_MEM_RD;
                    n_addr  = r_buf_addr;
                end else begin
                    n_from_mem = 1'b1;
                    n_head     = head_inc;
                    n_count    = r_count - CW'(1);
                    n_phase    = PH_RECV;
                    n_left     = r_buf_len - 32'd1;
                    n_kind     = KIND_MEM_WR;
                    n_addr     = r_buf_addr;
                    n_done     = (r_buf_len == 32'd1);
                    n_ptr      = r_buf_addr + 64'd1;
                end
            end
            OP_BAD_CMD: n_err = ERR_CMD;
            OP_BAD_WR:  n_err = ERR_OFFSET;
            OP_RD_READY: begin
                n_kind = KIND_BUS_RD;
                n_rd   = 32'(r_count);
            end
            OP_BAD_RD: begin
                n_kind = KIND_BUS_RD;
                n_err  = ERR_OFFSET;
            end
            OP_HOST: begin
                if (full) begin
                    n_err = ERR_REFUSED;
                end else begin
                    we      = 1'b1;
                    n_count = r_count + CW'(1);
                end
            end
            OP_RESP: begin
                if (r_second) begin
                    n_kind = KIND_MEM_RD;
                    n_addr = r_ptr;
                end else if (r_phase == PH_SEND) begin
                    n_left = r_left - 32'd1;
                    n_ptr  = r_ptr + 64'd1;
                    n_kind = KIND_TO_HOST;
                    n_byte = i_op.data;
                    if (r_left == 32'd1) begin
                        n_phase = PH_IDLE;
                        n_done  = 1'b1;
                    end else begin
                        n_second = 1'b1;
                        n_last   = 1'b0;
                    end
                end else if (r_phase == PH_RECV) begin
                    if (r_left == '0) begin
                        n_phase = PH_IDLE;
                    end else begin
                        if (r_count != '0) begin
                            n_from_mem = 1'b1;
                            n_head     = head_inc;
                            n_count    = r_count - CW'(1);
                        end
                        n_left = r_left - 32'd1;
                        n_kind = KIND_MEM_WR;
                        n_addr = r_ptr;
                        n_done = (r_left == 32'd1);
                        n_ptr  = r_ptr + 64'd1;
                    end
                end else begin
                    n_err = ERR_REFUSED;
                end
            end
            default: n_err = ERR_OK;
        endcase
        n_irq = n_irq_en && (n_count != '0);
    end

    assign o_op_ready = load && !n_second;

    always_ff @(posedge i_clk) begin
        if (load && we) begin
            r_store[wpos] <= i_op.data;
        end
        if (load && n_from_mem) begin
            r_rdata <= r_store[r_head];
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_kind     <= n_kind;
            r_rd       <= n_rd;
            r_addr     <= n_addr;
            r_byte     <= n_byte;
            r_from_mem <= n_from_mem;
            r_done     <= n_done;
            r_irq      <= n_irq;
            r_err      <= n_err;
            r_last     <= n_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head     <= '0;
            r_count    <= '0;
            r_irq_en   <= 1'b0;
            r_buf_addr <= '0;
            r_buf_len  <= '0;
            r_phase    <= PH_IDLE;
            r_ptr      <= '0;
            r_left     <= '0;
            r_second   <= 1'b0;
            r_valid    <= 1'b0;
        end else begin
            if (load) begin
                r_head     <= n_head;
                r_count    <= n_count;
                r_irq_en   <= n_irq_en;
                r_buf_addr <= n_buf_addr;
                r_buf_len  <= n_buf_len;
                r_phase    <= n_phase;
                r_ptr      <= n_ptr;
                r_left     <= n_left;
                r_second   <= n_second;
                r_valid    <= 1'b1;
            end else if (o_out.ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    assign o_out.valid       = r_valid;
    assign o_out.kind        = r_kind;
    assign o_out.read_data   = r_rd;
    assign o_out.mem_address = r_addr;
    assign o_out.data_byte   = r_from_mem ? r_rdata : r_byte;
    assign o_out.dma_done    = r_done;
    assign o_out.irq         = r_irq;
    assign o_out.error       = r_err;
    assign o_out.last        = r_last;

endmodule

### rtl/tfd_checker.sv
// ----------------------------------------------------------------------------
// tfd_checker
// Port-level checks on the result channel of the terminal device.
// ----------------------------------------------------------------------------
`include "tty_fifo_dma_device_top_assert.svh"

module tfd_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        i_ready,
    input logic [2:0]  i_kind,
    input logic [63:0] i_addr,
    input logic [7:0]  i_byte,
    input logic        i_done,
    input logic        i_last
);
    import tfd_pkg::*;

    `TFD_ASSERT_NEXT(a_hold, i_clk, i_rst_n, i_valid && !i_ready, i_valid && $stable(i_kind) && $stable(i_addr) && $stable(i_byte) && $stable(i_last))
    `TFD_ASSERT_IMPLY(a_done_kind, i_clk, i_rst_n, i_valid && i_done, i_last && (i_kind == KIND_TO_HOST || i_kind == KIND_MEM_WR))
    `TFD_ASSERT_IMPLY(a_first_kind, i_clk, i_rst_n, i_valid && !i_last, i_kind == KIND_TO_HOST && !i_done)
    `TFD_ASSERT_NEXT(a_second, i_clk, i_rst_n, i_valid && !i_last && i_ready, i_valid && i_last && i_kind == KIND_MEM_RD)
    `TFD_ASSERT_NEXT_ALWAYS(a_reset, i_clk, !i_rst_n, !i_valid)

endmodule

bind tty_fifo_dma_device_top tfd_checker u_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (o_out.valid),
    .i_ready (o_out.ready),
    .i_kind  (o_out.kind),
    .i_addr  (o_out.mem_address),
    .i_byte  (o_out.data_byte),
    .i_done  (o_out.dma_done),
    .i_last  (o_out.last)
);
